// ===== hw/rtl/hlbs_pkg.sv =====
package hlbs_pkg;

  // Table geometry and key format.
  localparam int MAX_POINTS = 256;
  localparam int KEY_W      = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  // Signed width for index sums and differences during the hunt.
  localparam int SW         = IDX_W + 3;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register selects, taken from the word address bit.
  localparam logic REG_POINT_COUNT   = 1'b0;
  localparam logic REG_WINDOW_POINTS = 1'b1;

  // Largest candidate fourth root that is scanned; covers tables up to 83520 entries.
  localparam int ROOT_SCAN = 16;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_SEARCH  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  // Result of the shared key comparator.
  typedef struct packed {
    logic ge;
    logic eq;
  } cmp_res_t;

  // Integer fourth root, at least one.
  function automatic logic [CNT_W-1:0] fourth_root(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = CNT_W'(1);
    for (int d = 2; d <= ROOT_SCAN; d++) begin
      if ((d * d * d * d) <= int'(n)) begin
        r = CNT_W'(d);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hlbs_ram.sv =====
module hlbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/hlbs_cmp.sv =====
module hlbs_cmp import hlbs_pkg::*; (
  input  logic [KEY_W-1:0] a,
  input  logic [KEY_W-1:0] b,
  output cmp_res_t         res
);

  // Two's complement signed compare of two keys, shared by every probe.
  always_comb begin
    res.ge = ($signed(a) >= $signed(b));
    res.eq = (a == b);
  end

endmodule

// ===== hw/rtl/hlbs_ctrl.sv =====
module hlbs_ctrl import hlbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] point_count,
  input  logic [CNT_W-1:0] window_points,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_opcode,
  input  logic [KEY_W-1:0] in_key_value,
  output logic [IDX_W-1:0] rd_addr,
  input  logic [KEY_W-1:0] rd_data,
  output logic [KEY_W-1:0] cmp_a,
  input  cmp_res_t         cmp_res,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_window_start,
  output logic [IDX_W-1:0] out_bracket_low,
  output logic             out_hunted
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_FIRST,
    S_HUNT0,
    S_HUP,
    S_HDN,
    S_BIS,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [KEY_W-1:0] x_r;
  logic [KEY_W-1:0] last_key_r;
  logic             ascnd_r;
  logic             hunted_r;
  logic [IDX_W-1:0] jl_r, jl_nxt;
  logic [IDX_W-1:0] ju_r, ju_nxt;
  logic [IDX_W-1:0] cand_r, cand_nxt;
  logic [CNT_W-1:0] inc_r, inc_nxt;
  logic             jl_eq_r, jl_eq_nxt;
  logic [IDX_W-1:0] last_br_r;
  logic             use_hunt_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_start_r;
  logic [IDX_W-1:0] out_low_r;
  logic             out_hunted_r;

  logic [CNT_W-1:0] n_s, m_s, nm1;
  logic             accept, gep, bis, done_go;
  logic signed [SW-1:0] base_s, step_s, up_s, dn_s, nm1_s;
  logic [CNT_W-1:0] span, mid_sum;
  logic signed [SW-1:0] jl_s, half_s, start_s, lim_s, diff_s;
  logic [IDX_W-1:0] start_v;
  logic             near;

  // Counts saturated into their legal ranges.
  always_comb begin
    n_s = point_count;
    if (n_s < CNT_W'(2)) n_s = CNT_W'(2);
    if (n_s > CNT_W'(MAX_POINTS)) n_s = CNT_W'(MAX_POINTS);
    m_s = window_points;
    if (m_s < CNT_W'(2)) m_s = CNT_W'(2);
    if (m_s > n_s) m_s = n_s;
    nm1   = n_s - CNT_W'(1);
    nm1_s = $signed({{(SW-CNT_W){1'b0}}, nm1});
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign cmp_a    = (state_r == S_FIRST) ? last_key_r : x_r;
  assign gep      = (cmp_res.ge == ascnd_r);

  // Hunt step: from the hint with a unit step, then from the probe with a doubled step.
  always_comb begin
    if (state_r == S_HUNT0) begin
      base_s = $signed({{(SW-IDX_W){1'b0}}, jl_r});
      step_s = SW'(1);
    end else begin
      base_s = $signed({{(SW-IDX_W){1'b0}}, cand_r});
      step_s = $signed({{(SW-CNT_W){1'b0}}, inc_r}) <<< 1;
    end
    up_s = base_s + step_s;
    dn_s = base_s - step_s;
  end

  // Sequencer: one table probe is evaluated each cycle while a search runs.
  always_comb begin
    state_nxt = state_r;
    jl_nxt    = jl_r;
    ju_nxt    = ju_r;
    cand_nxt  = cand_r;
    inc_nxt   = inc_r;
    jl_eq_nxt = jl_eq_r;
    rd_addr   = cand_r;
    bis       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_opcode == OP_SEARCH)) begin
          rd_addr   = nm1[IDX_W-1:0];
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        rd_addr   = '0;
        state_nxt = S_FIRST;
      end
      S_FIRST: begin
        if (!use_hunt_r || ({1'b0, last_br_r} > nm1)) begin
          jl_nxt = '0;
          ju_nxt = nm1[IDX_W-1:0];
          bis    = 1'b1;
        end else begin
          jl_nxt    = last_br_r;
          rd_addr   = last_br_r;
          state_nxt = S_HUNT0;
        end
      end
      S_HUNT0: begin
        jl_eq_nxt = cmp_res.eq;
        inc_nxt   = step_s[CNT_W-1:0];
        if (gep) begin
          if (up_s >= nm1_s) begin
            ju_nxt = nm1[IDX_W-1:0];
            bis    = 1'b1;
          end else begin
            cand_nxt  = up_s[IDX_W-1:0];
            rd_addr   = up_s[IDX_W-1:0];
            state_nxt = S_HUP;
          end
        end else begin
          ju_nxt = jl_r;
          if (dn_s <= SW'(0)) begin
            jl_nxt = '0;
            bis    = 1'b1;
          end else begin
            cand_nxt  = dn_s[IDX_W-1:0];
            rd_addr   = dn_s[IDX_W-1:0];
            state_nxt = S_HDN;
          end
        end
      end
      S_HUP: begin
        if (!gep || (cmp_res.eq && jl_eq_r)) begin
          ju_nxt = cand_r;
          bis    = 1'b1;
        end else begin
          jl_nxt    = cand_r;
          jl_eq_nxt = cmp_res.eq;
          if (up_s >= nm1_s) begin
            ju_nxt = nm1[IDX_W-1:0];
            bis    = 1'b1;
          end else begin
            inc_nxt   = step_s[CNT_W-1:0];
            cand_nxt  = up_s[IDX_W-1:0];
            rd_addr   = up_s[IDX_W-1:0];
          end
        end
      end
      S_HDN: begin
        if (gep) begin
          jl_nxt = cand_r;
          bis    = 1'b1;
        end else begin
          ju_nxt = cand_r;
          if (dn_s <= SW'(0)) begin
            jl_nxt = '0;
            bis    = 1'b1;
          end else begin
            inc_nxt  = step_s[CNT_W-1:0];
            cand_nxt = dn_s[IDX_W-1:0];
            rd_addr  = dn_s[IDX_W-1:0];
          end
        end
      end
      S_BIS: begin
        if (gep) begin
          jl_nxt = cand_r;
        end else begin
          ju_nxt = cand_r;
        end
        bis = 1'b1;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Bisection over the current bracket, or finish when it is one step wide.
    span    = {1'b0, ju_nxt} - {1'b0, jl_nxt};
    mid_sum = {1'b0, ju_nxt} + {1'b0, jl_nxt};
    if (bis) begin
      if (span > CNT_W'(1)) begin
        cand_nxt  = mid_sum[CNT_W-1:1];
        rd_addr   = mid_sum[CNT_W-1:1];
        state_nxt = S_BIS;
      end else begin
        state_nxt = S_DONE;
      end
    end
  end

  // Window start clamped to the table, and the closeness test for the next hint.
  always_comb begin
    jl_s    = $signed({{(SW-IDX_W){1'b0}}, jl_r});
    half_s  = $signed({{(SW-CNT_W){1'b0}}, m_s - CNT_W'(2)}) >>> 1;
    lim_s   = $signed({{(SW-CNT_W){1'b0}}, n_s - m_s});
    start_s = jl_s - half_s;
    if (start_s > lim_s) start_s = lim_s;
    if (start_s < SW'(0)) start_s = SW'(0);
    start_v = start_s[IDX_W-1:0];
    diff_s  = jl_s - $signed({{(SW-IDX_W){1'b0}}, last_br_r});
    if (diff_s < SW'(0)) diff_s = -diff_s;
    near    = (diff_s <= $signed({{(SW-CNT_W){1'b0}}, fourth_root(n_s)}));
  end

  assign done_go = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // State, search registers, hint and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_br_r   <= '0;
      use_hunt_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      jl_r     <= jl_nxt;
      ju_r     <= ju_nxt;
      cand_r   <= cand_nxt;
      inc_r    <= inc_nxt;
      jl_eq_r  <= jl_eq_nxt;
      if (accept) begin
        x_r      <= in_key_value;
        hunted_r <= use_hunt_r;
        if (in_opcode == OP_RESTART) begin
          last_br_r  <= '0;
          use_hunt_r <= 1'b1;
        end
      end
      if (state_r == S_LAST) begin
        last_key_r <= rd_data;
      end
      if (state_r == S_FIRST) begin
        ascnd_r <= cmp_res.ge;
      end
      if (done_go) begin
        out_valid_r  <= 1'b1;
        out_start_r  <= start_v;
        out_low_r    <= jl_r;
        out_hunted_r <= hunted_r;
        use_hunt_r   <= near;
        last_br_r    <= jl_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_start = out_start_r;
  assign out_bracket_low  = out_low_r;
  assign out_hunted       = out_hunted_r;

endmodule

// ===== hw/rtl/hunt_locate_bracket_search.sv =====
// Search beat: the sequencer reads the last and first keys, then makes H hunt probes and
// B bisection probes and loads the result register; the next beat is taken only once the
// sequencer is back in idle. One key table read per cycle goes through the single memory
// read port.
// Write, restart and unused beats are taken in idle and start no search.
// Reset (synchronous, rst_n low) clears the sequencer, the hint and the result valid, and
// sets both count registers to 2; table contents are undefined until written.
module hunt_locate_bracket_search import hlbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [IDX_W-1:0]  in_entry_index,
  input  logic signed [KEY_W-1:0] in_key_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_window_start,
  output logic [IDX_W-1:0]  out_bracket_low,
  output logic              out_hunted
);

  logic [CNT_W-1:0] point_count_r;
  logic [CNT_W-1:0] window_points_r;
  logic             cfg_wr;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_raddr;
  logic [KEY_W-1:0] tbl_rdata;
  logic [KEY_W-1:0] cmp_a;
  cmp_res_t         cmp_res;

  // Register access; the word address bit selects the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r   <= CNT_W'(2);
      window_points_r <= CNT_W'(2);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_POINT_COUNT) begin
        point_count_r <= pwdata[CNT_W-1:0];
      end else begin
        window_points_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_WINDOW_POINTS) begin
      prdata = {{(CFG_DW-CNT_W){1'b0}}, window_points_r};
    end else begin
      prdata = {{(CFG_DW-CNT_W){1'b0}}, point_count_r};
    end
  end

  // Key table, written by write beats.
  assign tbl_we = in_valid && in_ready && (in_opcode == OP_WRITE);

  hlbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (in_entry_index),
    .wr_data (in_key_value),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  // Shared comparator between the query (or last key) and the probed entry.
  hlbs_cmp u_cmp (
    .a   (cmp_a),
    .b   (tbl_rdata),
    .res (cmp_res)
  );

  hlbs_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .point_count      (point_count_r),
    .window_points    (window_points_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_key_value     (in_key_value),
    .rd_addr          (tbl_raddr),
    .rd_data          (tbl_rdata),
    .cmp_a            (cmp_a),
    .cmp_res          (cmp_res),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_start (out_window_start),
    .out_bracket_low  (out_bracket_low),
    .out_hunted       (out_hunted)
  );

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import hlbs_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic [KEY_W-1:0] KEY_ONE = 32'h0001_0000;
  localparam int ITEM_TARGET     = 650;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_LIMIT     = 2000;

  typedef struct packed {
    logic [IDX_W-1:0] window_start;
    logic [IDX_W-1:0] bracket_low;
    logic             hunted;
  } bracket_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed script; a register write uses index bit 0 as the select.
  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       opcode;
    logic [IDX_W-1:0] index;
    logic [KEY_W-1:0] value;
    logic             known;
    bracket_t         answer;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready, out_hunted;
  logic [1:0] in_opcode;
  logic [IDX_W-1:0] in_entry_index, out_window_start, out_bracket_low;
  logic signed [KEY_W-1:0] in_key_value;

  // Shadow copy of the block state used for prediction.
  logic signed [KEY_W-1:0] key_mem [MAX_POINTS];
  logic [IDX_W-1:0] hint_bracket = '0;
  logic hint_hunt = 1'b0;
  logic [CNT_W-1:0] reg_points = CNT_W'(2);
  logic [CNT_W-1:0] reg_window = CNT_W'(2);

  bracket_t expected_brackets [$];
  bit hold_off_req = 1'b0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int query_walk = 0;
  int items_sent = 0;
  int results_checked = 0;
  int hunted_searches = 0;
  int mismatches = 0;

  hunt_locate_bracket_search i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_entry_index   (in_entry_index),
    .in_key_value     (in_key_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_start (out_window_start),
    .out_bracket_low  (out_bracket_low),
    .out_hunted       (out_hunted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturated table size as the block sees it.
  function automatic int usable_points();
    if (reg_points < 2) return 2;
    if (reg_points > MAX_POINTS) return MAX_POINTS;
    return int'(reg_points);
  endfunction

  function automatic int quartic_floor(input int n);
    int d;
    d = 1;
    while ((d + 1) * (d + 1) * (d + 1) * (d + 1) <= n) d++;
    return d;
  endfunction

  // True when x lies at or beyond entry idx in the direction of the table.
  function automatic logic at_or_beyond(input logic signed [KEY_W-1:0] x, input int idx,
                                        input logic rising);
    return (x >= key_mem[idx]) == rising;
  endfunction

  // Hunt or bisect for the bracket of x, then update the hint as the block does.
  task automatic locate_bracket(input logic signed [KEY_W-1:0] x, output bracket_t res);
    int n, m, lo, hi, mid, step, span, start;
    logic rising, hunted;
    n = usable_points();
    m = (reg_window < 2) ? 2 : int'(reg_window);
    if (m > n) m = n;
    rising = key_mem[n-1] >= key_mem[0];
    hunted = hint_hunt;
    if (!hunted || int'(hint_bracket) > n - 1) begin
      lo = 0;
      hi = n - 1;
    end else begin
      step = 1;
      lo = int'(hint_bracket);
      if (at_or_beyond(x, lo, rising)) begin
        while (1) begin
          hi = lo + step;
          if (hi >= n - 1) begin
            hi = n - 1;
            break;
          end
          if (!at_or_beyond(x, hi, rising)) break;
          // A run of keys equal to the query ends the upward hunt.
          if (x == key_mem[hi] && x == key_mem[lo]) break;
          lo = hi;
          step += step;
        end
      end else begin
        hi = lo;
        while (1) begin
          lo = lo - step;
          if (lo <= 0) begin
            lo = 0;
            break;
          end
          if (at_or_beyond(x, lo, rising)) break;
          hi = lo;
          step += step;
        end
      end
    end
    while (hi - lo > 1) begin
      mid = (hi + lo) >> 1;
      if (at_or_beyond(x, mid, rising)) lo = mid;
      else hi = mid;
    end
    span = lo - int'(hint_bracket);
    if (span < 0) span = -span;
    hint_hunt = (span <= quartic_floor(n));
    hint_bracket = IDX_W'(lo);
    start = lo - ((m - 2) >> 1);
    if (start > n - m) start = n - m;
    if (start < 0) start = 0;
    res.window_start = IDX_W'(start);
    res.bracket_low = IDX_W'(lo);
    res.hunted = hunted;
    if (hunted) hunted_searches++;
  endtask

  task automatic flag_mismatch(input string field, input int got, input int want);
    if (mismatches < 100) begin
      $display("%0t: %s is %0d, expected %0d", $time, field, got, want);
    end
    mismatches++;
  endtask

  // Offer one beat, wait for it to be taken, then update the shadow state.
  task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [KEY_W-1:0] key, input bit known = 1'b0,
                           input bracket_t answer = '0);
    int gap;
    bracket_t res;
    if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_entry_index <= idx;
    in_key_value <= key;
    do @(posedge clk); while (in_ready !== 1'b1);
    case (op)
      OP_WRITE: key_mem[idx] = key;
      OP_RESTART: begin
        hint_bracket = '0;
        hint_hunt = 1'b1;
      end
      OP_SEARCH: begin
        locate_bracket(key, res);
        expected_brackets.push_back(known ? answer : res);
      end
      default: ;
    endcase
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Let every pending result come out and the block go quiet.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_brackets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [CNT_W-1:0] value);
    settle_block();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    if (sel == REG_POINT_COUNT) reg_points = value;
    else reg_window = value;
  endtask

  task automatic set_counts(input int points, input int window);
    write_register(REG_POINT_COUNT, CNT_W'(points));
    write_register(REG_WINDOW_POINTS, CNT_W'(window));
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(0, 7))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    endcase
  endfunction

  // Queries mostly walk along the table so that the hunt gets exercised.
  function automatic logic [KEY_W-1:0] pick_query();
    int n;
    n = usable_points();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return random_key();
      2, 3: return key_mem[$urandom_range(0, n - 1)];
      default: begin
        query_walk = query_walk + $urandom_range(0, 6) - 3;
        if (query_walk < 0) query_walk = 0;
        if (query_walk > n - 1) query_walk = n - 1;
        return key_mem[query_walk] + KEY_W'($urandom_range(0, 4)) - 32'd2;
      end
    endcase
  endfunction

  // Load entries 0..count-1 with a sorted run, ascending or descending, with repeats.
  task automatic fill_table(input int count);
    int keys [$];
    for (int i = 0; i < count; i++) keys.push_back(int'(random_key()));
    if ($urandom_range(0, 1) == 0) keys.sort();
    else keys.rsort();
    for (int i = 1; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) keys[i] = keys[i-1];
    end
    for (int i = 0; i < count; i++) send_item(OP_WRITE, IDX_W'(i), KEY_W'(keys[i]));
  endtask

  // Mostly searches, with restarts, stray writes and unused opcodes mixed in.
  task automatic run_traffic(input int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) send_item(OP_SEARCH, IDX_W'($urandom()), pick_query());
      else if (pick < 87) send_item(OP_RESTART, IDX_W'($urandom()), $urandom());
      else if (pick < 96) send_item(OP_WRITE, IDX_W'($urandom()), random_key());
      else send_item(OP_UNUSED, IDX_W'($urandom()), $urandom());
    end
  endtask

  function automatic script_row_t row_item(input logic [1:0] op, input int idx,
                                           input logic [KEY_W-1:0] key);
    return '{ROW_ITEM, op, IDX_W'(idx), key, 1'b0, bracket_t'(0)};
  endfunction

  function automatic script_row_t row_known(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                            input int ws, input int bl, input logic h);
    return '{ROW_ITEM, op, '0, key, 1'b1, bracket_t'{IDX_W'(ws), IDX_W'(bl), h}};
  endfunction

  function automatic script_row_t row_cfg(input logic sel, input int value);
    return '{ROW_CFG, OP_WRITE, IDX_W'(sel), KEY_W'(value), 1'b0, bracket_t'(0)};
  endfunction

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    bracket_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_checked++;
      if (expected_brackets.size() == 0) begin
        flag_mismatch("unexpected result, bracket_low", out_bracket_low, -1);
      end else begin
        want = expected_brackets.pop_front();
        if (out_window_start !== want.window_start) begin
          flag_mismatch("window_start", out_window_start, want.window_start);
        end
        if (out_bracket_low !== want.bracket_low) begin
          flag_mismatch("bracket_low", out_bracket_low, want.bracket_low);
        end
        if (out_hunted !== want.hunted) flag_mismatch("hunted", out_hunted, want.hunted);
      end
    end
  end

  // Result side: random stalls per beat, steady stretches, and one long hold-off.
  initial begin
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Give up when nothing moves on any port for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) === 1'b1 || (out_valid && out_ready) === 1'b1 ||
          (psel && penable && pwrite && pready) === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    script_row_t script [$];
    int points;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= OP_WRITE;
    in_entry_index <= '0;
    in_key_value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes, every opcode, equal keys, both directions, stale hint.
    script = '{
      row_item(OP_WRITE, 0, KEY_MIN),
      row_item(OP_WRITE, 1, KEY_MAX),
      row_known(OP_SEARCH, '0, 0, 0, 1'b0),
      row_known(OP_SEARCH, KEY_MIN, 0, 0, 1'b1),
      row_item(OP_UNUSED, 255, 32'hFFFF_FFFF),
      row_item(OP_RESTART, 0, '0),
      row_known(OP_SEARCH, KEY_MAX, 0, 0, 1'b1),
      row_cfg(REG_POINT_COUNT, 5),
      row_cfg(REG_WINDOW_POINTS, 3),
      row_item(OP_WRITE, 1, KEY_ONE),
      row_item(OP_WRITE, 2, KEY_ONE),
      row_item(OP_WRITE, 3, KEY_ONE),
      row_item(OP_WRITE, 4, KEY_MAX),
      row_item(OP_SEARCH, 0, KEY_ONE),
      row_item(OP_SEARCH, 0, KEY_ONE),
      row_item(OP_SEARCH, 0, -KEY_ONE),
      row_item(OP_WRITE, 0, KEY_MAX),
      row_item(OP_WRITE, 4, KEY_MIN),
      row_item(OP_SEARCH, 0, '0),
      row_item(OP_SEARCH, 0, KEY_MIN),
      row_item(OP_SEARCH, 0, KEY_MIN),
      row_cfg(REG_POINT_COUNT, 2),
      row_item(OP_SEARCH, 0, '0),
      row_cfg(REG_POINT_COUNT, 0),
      row_cfg(REG_WINDOW_POINTS, 0),
      row_item(OP_SEARCH, 0, KEY_MAX)
    };
    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        write_register(script[r].index[0], script[r].value[CNT_W-1:0]);
      end else begin
        send_item(script[r].opcode, script[r].index, script[r].value, script[r].known,
                  script[r].answer);
      end
    end

    // Full table once, then large and odd settings over the same sorted contents.
    set_counts(256, 256);
    fill_table(MAX_POINTS);
    run_traffic(30);
    set_counts(256, 2);
    run_traffic(30);
    set_counts(511, 1);
    run_traffic(25);
    set_counts(100, 7);
    run_traffic(25);
    set_counts(300, 257);
    run_traffic(20);

    // Mostly small tables, refilled in every phase of 32 keys or fewer; the first phase also backs up the result side.
    hold_off_req = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) points = $urandom_range(0, 511);
      else points = $urandom_range(2, 32);
      set_counts(points, (points + 3 > 511) ? 511 : $urandom_range(0, points + 3));
      if (usable_points() <= 32) fill_table(usable_points());
      query_walk = 0;
      run_traffic($urandom_range(15, 40));
    end

    settle_block();
    $display("Sent %0d beats, checked %0d brackets, %0d of them found by hunting.",
             items_sent, results_checked, hunted_searches);
    $display("Tables of 2 to 256 keys in both directions, with %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== hunt_locate_bracket_search.f =====
hw/rtl/hlbs_pkg.sv
hw/rtl/hlbs_ram.sv
hw/rtl/hlbs_cmp.sv
hw/rtl/hlbs_ctrl.sv
hw/rtl/hunt_locate_bracket_search.sv
verif/testbench.sv
